// ===== hw/rtl/ptns_pkg.sv =====
package ptns_pkg;

  // Field widths.
  localparam int RmsW    = 16;
  localparam int PitchW  = 24;
  localparam int NoteW   = 7;
  localparam int FrameW  = 32;
  localparam int SumW    = 48;
  localparam int VelW    = 7;
  localparam int ThrW    = 22;
  // Width of the shared compare/subtract unit: holds rms_sum * 1016.
  localparam int AluW    = 58;
  localparam int NoteMax = 127;
  localparam int TopIdx  = 128;

  localparam logic [63:0] TopScale = 64'd1802240;
  localparam logic [63:0] RatioOne = 64'd1000000000000;

  typedef logic [63:0] ratio_tab_t [0:11];

  localparam ratio_tab_t TopRatio = '{
    64'd971531941154,  64'd1029302236643, 64'd1090507732665, 64'd1155352696872,
    64'd1224053543305, 64'd1296839554651, 64'd1373953647458, 64'd1455653182842,
    64'd1542210825408, 64'd1633915453241, 64'd1731073122012, 64'd1834008086409
  };

  typedef logic [TopIdx:0][ThrW-1:0] thr_tab_t;

  // Lower boundary of note n in Q16.8, rounded up. The top octave is held
  // exactly and each lower octave halves it; a ceiling of a ceiling gives
  // the same result as one ceiling over the whole quotient.
  function automatic logic [63:0] note_threshold(input int n);
    int          s;
    int          m;
    logic [63:0] num;
    logic [63:0] q;
    s   = (128 - n) / 12;
    m   = n + 12 * s - 117;
    num = TopScale * TopRatio[m];
    q   = (num + RatioOne - 64'd1) / RatioOne;
    return (q + (64'd1 << s) - 64'd1) >> s;
  endfunction

  // Entry 0 is zero so that the search for the highest boundary below the
  // pitch can start from note zero.
  function automatic thr_tab_t build_thr();
    thr_tab_t t;
    t = '0;
    for (int i = 1; i <= TopIdx; i++) begin
      t[i] = ThrW'(note_threshold(i));
    end
    return t;
  endfunction

  localparam thr_tab_t NoteThr = build_thr();

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK_TOP,
    ST_LOOKUP,
    ST_DECIDE,
    ST_MUL,
    ST_DIV_TOP,
    ST_DIV,
    ST_EMIT,
    ST_COMMIT
  } state_t;

endpackage

// ===== hw/rtl/pitch_track_note_segmenter_core.sv =====
// Note segmenter for a stream of pitch-tracked analysis frames.
// Input channel (in_*): one beat per frame. in_tdata carries the frame RMS
// and the pitch estimate; in_tuser is the operation, zero for a frame and
// one for an end-of-stream flush. Output channel (out_*): one beat per
// finished note with its number, start and end frame and velocity.
// Configuration: cfg_wr_en writes cfg_wr_data into the silence level.
// Each input beat is worked on alone: the block drops in_tready until it
// is done. A single compare/subtract unit first runs a binary search over
// the note-boundary table (one boundary test per cycle, eight in all),
// then, when a note ends, a restoring division of the scaled RMS sum by the
// scaled run length for the velocity, which stops after its first trial
// subtraction when the velocity clamps at the top. The block waits in its
// emit state while the output register is still full.
// The result sits in an output register, so a receiver that stalls holds
// back the block only when the next note is finished before the previous
// one has been taken. Synchronous reset (rst_n low) clears the tracker,
// empties the output register and sets the silence level to 655.
module pitch_track_note_segmenter_core (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // silence_level
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,      // frame_rms[15:0], pitch_freq[39:16]
  input  logic [0:0]  in_tuser,      // op: 0 frame, 1 flush
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata      // note_number[6:0], start_frame[38:7],
                                     // end_frame[70:39], velocity[77:71],
                                     // zero pad[79:78]
);

  localparam int RmsW   = ptns_pkg::RmsW;
  localparam int PitchW = ptns_pkg::PitchW;
  localparam int NoteW  = ptns_pkg::NoteW;
  localparam int FrameW = ptns_pkg::FrameW;
  localparam int SumW   = ptns_pkg::SumW;
  localparam int VelW   = ptns_pkg::VelW;
  localparam int AluW   = ptns_pkg::AluW;

  ptns_pkg::state_t state_r, state_nxt;

  // Configuration.
  logic [RmsW-1:0]   silence_r;

  // Latched input beat.
  logic              op_r;
  logic [RmsW-1:0]   rms_r;
  logic [PitchW-1:0] pitch_r;

  // Tracker state.
  logic [NoteW-1:0]  cur_note_r, cur_note_nxt;
  logic [FrameW-1:0] note_start_r, note_start_nxt;
  logic [SumW-1:0]   rms_sum_r, rms_sum_nxt;
  logic [FrameW-1:0] run_r, run_nxt;
  logic [FrameW-1:0] frame_idx_r, frame_idx_nxt;

  // Sequencer working registers.
  logic [2:0]        cnt_r, cnt_nxt;
  logic [NoteW-1:0]  note_r, note_nxt;     // search result, then detected note
  logic              over_r, over_nxt;     // pitch at or above the top boundary
  logic [AluW-1:0]   rem_r, rem_nxt;
  logic [SumW-1:0]   den_r, den_nxt;
  logic [VelW-1:0]   quo_r, quo_nxt;
  logic              sat_r, sat_nxt;       // quotient exceeds the velocity range

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [79:0]       out_data_r, out_data_nxt;

  // Shared compare/subtract unit.
  logic [AluW-1:0]   alu_a, alu_b;
  logic [AluW:0]     alu_diff;
  logic              alu_ge;
  logic [NoteW-1:0]  cand;
  logic [NoteW-1:0]  step_bit;
  logic              out_free;
  logic              accept;
  logic              need_emit;
  logic [NoteW-1:0]  heard;
  logic [SumW:0]     sum_add;
  logic [AluW-1:0]   sum_ext;
  logic [VelW-1:0]   vel;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ptns_pkg::ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign need_emit = (cur_note_r != '0) && (run_r != '0);
  assign step_bit  = NoteW'(1) << cnt_r;
  assign cand      = note_r | step_bit;
  assign sum_ext   = AluW'(rms_sum_r);
  assign sum_add   = {1'b0, rms_sum_r} + (SumW + 1)'(rms_r);

  // Silent frames and pitches past the top note are unvoiced.
  assign heard = (over_r || (rms_r < silence_r)) ? '0 : note_r;

  // Operand selection: boundary tests during the search, trial subtractions
  // of the shifted divisor during the division.
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_r)
      ptns_pkg::ST_CHECK_TOP: begin
        alu_a = AluW'(pitch_r);
        alu_b = AluW'(ptns_pkg::NoteThr[ptns_pkg::TopIdx]);
      end
      ptns_pkg::ST_LOOKUP: begin
        alu_a = AluW'(pitch_r);
        alu_b = AluW'(ptns_pkg::NoteThr[{1'b0, cand}]);
      end
      ptns_pkg::ST_DIV_TOP: begin
        alu_a = rem_r;
        alu_b = AluW'(den_r) << VelW;
      end
      ptns_pkg::ST_DIV: begin
        alu_a = rem_r;
        alu_b = AluW'(den_r) << cnt_r;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ge   = !alu_diff[AluW];

  // Velocity from the quotient, clamped to 1..127.
  assign vel = sat_r ? VelW'(ptns_pkg::NoteMax) : ((quo_r == '0) ? VelW'(1) : quo_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptns_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = in_tuser[0] ? ptns_pkg::ST_DECIDE : ptns_pkg::ST_CHECK_TOP;
        end
      end
      ptns_pkg::ST_CHECK_TOP: state_nxt = ptns_pkg::ST_LOOKUP;
      ptns_pkg::ST_LOOKUP: begin
        if (cnt_r == '0) begin
          state_nxt = ptns_pkg::ST_DECIDE;
        end
      end
      ptns_pkg::ST_DECIDE: begin
        if (op_r) begin
          state_nxt = need_emit ? ptns_pkg::ST_MUL : ptns_pkg::ST_COMMIT;
        end else if (heard != cur_note_r && need_emit) begin
          state_nxt = ptns_pkg::ST_MUL;
        end else begin
          state_nxt = ptns_pkg::ST_COMMIT;
        end
      end
      ptns_pkg::ST_MUL:     state_nxt = ptns_pkg::ST_DIV_TOP;
      ptns_pkg::ST_DIV_TOP: state_nxt = alu_ge ? ptns_pkg::ST_EMIT : ptns_pkg::ST_DIV;
      ptns_pkg::ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ptns_pkg::ST_EMIT;
        end
      end
      ptns_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = ptns_pkg::ST_COMMIT;
        end
      end
      ptns_pkg::ST_COMMIT:  state_nxt = ptns_pkg::ST_IDLE;
      default:              state_nxt = ptns_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output control.
  always_comb begin
    cur_note_nxt   = cur_note_r;
    note_start_nxt = note_start_r;
    rms_sum_nxt    = rms_sum_r;
    run_nxt        = run_r;
    frame_idx_nxt  = frame_idx_r;
    cnt_nxt        = cnt_r;
    note_nxt       = note_r;
    over_nxt       = over_r;
    rem_nxt        = rem_r;
    den_nxt        = den_r;
    quo_nxt        = quo_r;
    sat_nxt        = sat_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;

    unique case (state_r)
      ptns_pkg::ST_IDLE: begin
        note_nxt = '0;
        cnt_nxt  = 3'(NoteW - 1);
      end
      ptns_pkg::ST_CHECK_TOP: begin
        over_nxt = alu_ge;
      end
      ptns_pkg::ST_LOOKUP: begin
        if (alu_ge) begin
          note_nxt = cand;
        end
        cnt_nxt = cnt_r - 3'd1;
      end
      ptns_pkg::ST_DECIDE: begin
        note_nxt = heard;
      end
      ptns_pkg::ST_MUL: begin
        // rms_sum * 1016 as (rms_sum << 10) - (rms_sum << 3).
        rem_nxt = (sum_ext << 10) - (sum_ext << 3);
        den_nxt = {run_r[SumW-17:0], 16'd0};
        quo_nxt = '0;
        cnt_nxt = 3'(VelW - 1);
      end
      ptns_pkg::ST_DIV_TOP: begin
        sat_nxt = alu_ge;
      end
      ptns_pkg::ST_DIV: begin
        if (alu_ge) begin
          rem_nxt = alu_diff[AluW-1:0];
          quo_nxt = quo_r | (VelW'(1) << cnt_r);
        end
        cnt_nxt = cnt_r - 3'd1;
      end
      ptns_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, vel, frame_idx_r, note_start_r, cur_note_r};
        end
      end
      ptns_pkg::ST_COMMIT: begin
        if (op_r) begin
          cur_note_nxt   = '0;
          note_start_nxt = '0;
          rms_sum_nxt    = '0;
          run_nxt        = '0;
          frame_idx_nxt  = '0;
        end else begin
          if (note_r == cur_note_r) begin
            rms_sum_nxt = sum_add[SumW] ? '1 : sum_add[SumW-1:0];
            if (run_r != '1) begin
              run_nxt = run_r + FrameW'(1);
            end
          end else begin
            cur_note_nxt   = note_r;
            note_start_nxt = frame_idx_r;
            rms_sum_nxt    = SumW'(rms_r);
            run_nxt        = FrameW'(1);
          end
          frame_idx_nxt = frame_idx_r + FrameW'(1);
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ptns_pkg::ST_IDLE;
      silence_r    <= RmsW'(655);
      cur_note_r   <= '0;
      note_start_r <= '0;
      rms_sum_r    <= '0;
      run_r        <= '0;
      frame_idx_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wr_en) begin
        silence_r <= cfg_wr_data;
      end
      cur_note_r   <= cur_note_nxt;
      note_start_r <= note_start_nxt;
      rms_sum_r    <= rms_sum_nxt;
      run_r        <= run_nxt;
      frame_idx_r  <= frame_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Working registers, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_tuser[0];
      rms_r   <= in_tdata[15:0];
      pitch_r <= in_tdata[39:16];
    end
    cnt_r      <= cnt_nxt;
    note_r     <= note_nxt;
    over_r     <= over_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    quo_r      <= quo_nxt;
    sat_r      <= sat_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== tb/sv/ptns_tb_pkg.sv =====
package ptns_tb_pkg;

  // Operation carried in in_tuser.
  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_FLUSH = 1'b1
  } seg_op_t;

  // One finished note as it leaves the block.
  typedef struct packed {
    logic [6:0]  note_number;
    logic [31:0] start_frame;
    logic [31:0] end_frame;
    logic [6:0]  velocity;
  } note_rec_t;

endpackage

// ===== tb/sv/ptns_note_checker.sv =====
module ptns_note_checker import ptns_pkg::*, ptns_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,      // frame_rms[15:0], pitch_freq[39:16]
  input  logic [0:0]  in_tuser,      // op
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,     // note, start, end, velocity, pad
  output int          fail_count,
  output int          notes_waiting,
  output int          notes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [RmsW-1:0]   QuietReset = 16'd655;
  localparam logic [SumW-1:0]   SumCeil    = '1;
  localparam logic [FrameW-1:0] RunCeil    = '1;
  localparam longint unsigned   BendScale  = 64'd1802240;
  localparam longint unsigned   UnitRatio  = 64'd1000000000000;

  logic [RmsW-1:0]   quiet_thr;
  logic [NoteW-1:0]  cur_note;
  logic [FrameW-1:0] run_start;
  logic [FrameW-1:0] run_len;
  logic [FrameW-1:0] frame_idx;
  logic [SumW-1:0]   level_sum;
  note_rec_t         notes_due[$];
  longint unsigned   note_floor [1:128];

  // Semitone ratios of the top octave, scaled by 1e12.
  function automatic longint unsigned octave_ratio(input int m);
    case (m)
      0:       return 64'd971531941154;
      1:       return 64'd1029302236643;
      2:       return 64'd1090507732665;
      3:       return 64'd1155352696872;
      4:       return 64'd1224053543305;
      5:       return 64'd1296839554651;
      6:       return 64'd1373953647458;
      7:       return 64'd1455653182842;
      8:       return 64'd1542210825408;
      9:       return 64'd1633915453241;
      10:      return 64'd1731073122012;
      default: return 64'd1834008086409;
    endcase
  endfunction

  initial begin
    int              s;
    longint unsigned num;
    longint unsigned den;
    for (int n = 1; n <= TopIdx; n++) begin
      s   = (128 - n) / 12;
      num = BendScale * octave_ratio(n + 12 * s - 117);
      den = UnitRatio << s;
      note_floor[n] = (num + den - 64'd1) / den;
    end
  end

  function automatic logic [NoteW-1:0] pitch_note(input logic [PitchW-1:0] p);
    logic [NoteW-1:0] hit;
    hit = '0;
    if (p == '0 || p >= note_floor[TopIdx]) return '0;
    for (int n = 1; n <= NoteMax; n++) begin
      if (note_floor[n] <= p) hit = NoteW'(n);
    end
    return hit;
  endfunction

  function automatic note_rec_t finished_note();
    note_rec_t       r;
    longint unsigned scaled;
    longint unsigned q;
    scaled        = longint'(level_sum) * 64'd1016;
    q             = scaled / ({32'd0, run_len} << 16);
    r.note_number = cur_note;
    r.start_frame = run_start;
    r.end_frame   = frame_idx;
    r.velocity    = (q < 1) ? 7'd1 : (q > 127) ? 7'd127 : q[6:0];
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : track
    logic [RmsW-1:0]   rms;
    logic [PitchW-1:0] pitch;
    logic [NoteW-1:0]  heard;
    logic [SumW:0]     sum_wide;
    note_rec_t         want;
    note_rec_t         got;
    if (!rst_n) begin
      quiet_thr     = QuietReset;
      cur_note      = '0;
      run_start     = '0;
      run_len       = '0;
      frame_idx     = '0;
      level_sum     = '0;
      fail_count    = 0;
      notes_checked = 0;
      notes_due.delete();
    end else begin
      if (cfg_wr_en) quiet_thr = cfg_wr_data;

      if (in_tvalid && in_tready) begin
        rms   = in_tdata[15:0];
        pitch = in_tdata[39:16];
        if (seg_op_t'(in_tuser) == OP_FLUSH) begin
          if (cur_note != '0 && run_len != '0) notes_due = {notes_due, finished_note()};
          cur_note  = '0;
          run_start = '0;
          run_len   = '0;
          frame_idx = '0;
          level_sum = '0;
        end else begin
          heard = (rms >= quiet_thr) ? pitch_note(pitch) : '0;
          if (heard == cur_note) begin
            sum_wide  = level_sum + rms;
            level_sum = sum_wide[SumW] ? SumCeil : sum_wide[SumW-1:0];
            if (run_len != RunCeil) run_len++;
          end else begin
            if (cur_note != '0 && run_len != '0) notes_due = {notes_due, finished_note()};
            cur_note  = heard;
            run_start = frame_idx;
            level_sum = SumW'(rms);
            run_len   = 1;
          end
          frame_idx++;
        end
      end

      if (out_tvalid && out_tready) begin
        got.note_number = out_tdata[6:0];
        got.start_frame = out_tdata[38:7];
        got.end_frame   = out_tdata[70:39];
        got.velocity    = out_tdata[77:71];
        if (notes_due.size() == 0) begin
          $display("%0t: unexpected note beat, expected none, got note %0d frames %0d..%0d",
                   $time, got.note_number, got.start_frame, got.end_frame);
          fail_count++;
        end else begin
          want = notes_due.pop_front();
          check_field("note_number", want.note_number, got.note_number);
          check_field("start_frame", want.start_frame, got.start_frame);
          check_field("end_frame", want.end_frame, got.end_frame);
          check_field("velocity", want.velocity, got.velocity);
          notes_checked++;
        end
      end
    end
    notes_waiting = notes_due.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ptns_pkg::*;
  import ptns_tb_pkg::*;

  // The run is cut off here.
  localparam int CycleLimit   = 600000;
  // Covers a beat that is still being worked on inside the block when the
  // output is free.
  localparam int SettleCycles = 40;
  // Length of the one long receiver hold-off that backs up the input.
  localparam int HoldCycles   = 600;
  localparam int HoldAfter    = 300;
  localparam int PhaseBeats   = 213;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_tvalid;
  wire         in_tready;
  logic [39:0] in_tdata;
  logic [0:0]  in_tuser;
  wire         out_tvalid;
  logic        out_tready;
  wire  [79:0] out_tdata;

  int          fail_count;
  int          notes_waiting;
  int          notes_checked;

  // Bookkeeping on the stimulus side.
  int          beats_sent   = 0;
  int          flushes_sent = 0;
  int          levels_used  = 0;
  int          burst_left   = 0;
  bit          idle_gaps    = 1'b0;
  logic [15:0] silence      = 16'd655;
  longint      cycle_count  = 0;

  pitch_track_note_segmenter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // The checker sits beside the block, sees both channels and the
  // configuration port, and reports how many checks failed.
  ptns_note_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .notes_waiting(notes_waiting),
    .notes_checked(notes_checked)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("FAILURE");
    $finish;
  end

  // Offers one beat and returns at the edge where it is taken. Bursts of
  // random length are separated by random gaps when idle_gaps is set, so
  // the gaps land on every phase of the block's internal sequence.
  task automatic send_item(input seg_op_t op, input logic [15:0] rms,
                           input logic [23:0] pitch);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      if (idle_gaps) begin
        gap = $urandom_range(12, 0);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {pitch, rms};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    if (op == OP_FLUSH) flushes_sent++;
  endtask

  // Stops offering, lets the last beat reach the checker's books, waits for
  // every predicted note to come out, then lets the block finish whatever
  // beat follows the last note.
  task automatic wait_drained();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    repeat (SettleCycles) @(posedge clk);
    wait (notes_waiting == 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // The silence level is only changed while the block is idle.
  task automatic set_silence(input logic [15:0] level);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= level;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    silence     = level;
    levels_used++;
  endtask

  // An RMS value that passes the silence gate. Half the time it is kept
  // low enough that the velocity is not simply clamped at the top.
  function automatic logic [15:0] loud_rms();
    int hi;
    hi = ($urandom_range(1, 0) == 1) ? 65535 : int'(silence) + 8000;
    if (hi > 65535) hi = 65535;
    return 16'($urandom_range(hi, int'(silence)));
  endfunction

  function automatic logic [15:0] quiet_rms();
    if (silence == 16'd0) return loud_rms();
    return 16'($urandom_range(int'(silence) - 1, 0));
  endfunction

  // A pitch that lands anywhere inside the band of note n.
  function automatic logic [23:0] note_pitch(input int n);
    return 24'($urandom_range(int'(NoteThr[n + 1]) - 1, int'(NoteThr[n])));
  endfunction

  // Random traffic. Most of it is held notes with random content, since
  // only runs of matching frames build up sums and lengths worth checking;
  // the rest is unvoiced frames, flushes and raw noise on every bit.
  task automatic play_random(input int budget);
    int          sent;
    int          kind;
    int          len;
    int          n;
    logic [15:0] rms;
    logic [23:0] pitch;
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(99, 0);
      if (kind < 68) begin
        n   = $urandom_range(127, 1);
        len = $urandom_range(6, 1);
        repeat (len) begin
          rms = ($urandom_range(9, 0) == 0) ? quiet_rms() : loud_rms();
          send_item(OP_FRAME, rms, note_pitch(n));
          sent++;
        end
      end else if (kind < 80) begin
        case ($urandom_range(3, 0))
          0:       pitch = 24'd0;
          1:       pitch = 24'($urandom_range(int'(NoteThr[1]) - 1, 1));
          2:       pitch = 24'($urandom_range(24'hFFFFFF, int'(NoteThr[TopIdx])));
          default: pitch = note_pitch($urandom_range(127, 1));
        endcase
        rms = (pitch != 24'd0 && pitch < NoteThr[TopIdx] && pitch >= NoteThr[1])
              ? quiet_rms() : loud_rms();
        send_item(OP_FRAME, rms, pitch);
        sent++;
      end else if (kind < 86) begin
        send_item(OP_FLUSH, 16'($urandom_range(65535, 0)), 24'($urandom_range(24'hFFFFFF, 0)));
        sent++;
      end else begin
        send_item(seg_op_t'($urandom_range(1, 0)), 16'($urandom_range(65535, 0)),
                  24'($urandom_range(24'hFFFFFF, 0)));
        sent++;
      end
    end
  endtask

  // Receiver: stretches of always-ready, half-ready and mostly-stalled
  // cycles, plus one long hold-off once enough beats have gone in. During
  // that hold the sender keeps offering, so the output register fills and
  // the block has to drop in_tready.
  initial begin : receiver
    int  mode;
    int  len;
    bit  held;
    out_tready = 1'b0;
    held       = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held && beats_sent >= HoldAfter) begin
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        held = 1'b1;
      end else begin
        mode = $urandom_range(2, 0);
        len  = $urandom_range(80, 10);
        repeat (len) begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= ($urandom_range(1, 0) == 1);
            default: out_tready <= ($urandom_range(3, 0) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    logic [15:0] levels [6];
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 16'd0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_FRAME;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the default level, written explicitly once.
    set_silence(16'd655);
    send_item(OP_FRAME, 16'd1000, 24'd0);                    // zero pitch
    send_item(OP_FRAME, 16'd1000, 24'(NoteThr[1] - 1));      // just below note 1
    send_item(OP_FRAME, 16'd654, 24'(NoteThr[60]));          // one step under silence
    send_item(OP_FRAME, 16'd655, 24'(NoteThr[1]));           // exactly at the gate, note 1
    send_item(OP_FRAME, 16'd65535, 24'(NoteThr[2] - 1));     // top of note 1's band
    send_item(OP_FRAME, 16'd700, 24'(NoteThr[TopIdx] - 1));  // highest note, ends note 1
    send_item(OP_FRAME, 16'd65535, 24'(NoteThr[127]));
    send_item(OP_FRAME, 16'd1000, 24'hFFFFFF);               // full-scale pitch, unvoiced
    send_item(OP_FRAME, 16'd1000, 24'(NoteThr[TopIdx]));     // first pitch above note 127
    send_item(OP_FLUSH, 16'd0, 24'd0);                       // flush with nothing held
    send_item(OP_FLUSH, 16'hFFFF, 24'hFFFFFF);               // back-to-back flush
    send_item(OP_FRAME, 16'd65535, 24'(NoteThr[69]));        // loud A4, velocity clamps high
    send_item(OP_FRAME, 16'd65535, 24'(NoteThr[70] - 1));
    send_item(OP_FRAME, 16'd0, 24'(NoteThr[64]));            // silent frame ends it
    send_item(OP_FLUSH, 16'd0, 24'd0);

    // Gate fully open: a zero level makes even silent frames voiced and
    // drives the velocity to its lower clamp; the flush closes that note.
    set_silence(16'd0);
    send_item(OP_FRAME, 16'd0, 24'(NoteThr[40]));
    send_item(OP_FRAME, 16'd0, 24'(NoteThr[41] - 1));
    send_item(OP_FLUSH, 16'd0, 24'd0);

    // Gate fully closed except for full-scale RMS.
    set_silence(16'hFFFF);
    send_item(OP_FRAME, 16'hFFFF, 24'(NoteThr[100]));
    send_item(OP_FRAME, 16'hFFFE, 24'(NoteThr[100]));
    send_item(OP_FLUSH, 16'd0, 24'd0);

    // Random phases, each under its own silence level. Odd phases keep the
    // sender busy with no gaps at all.
    levels = '{16'($urandom_range(65535, 0)), 16'd0, 16'hFFFF, 16'd3000,
               16'($urandom_range(2000, 0)), 16'd655};
    for (int ph = 0; ph < 6; ph++) begin
      set_silence(levels[ph]);
      idle_gaps = (ph % 2 == 0);
      play_random(PhaseBeats);
    end
    send_item(OP_FLUSH, 16'd0, 24'd0);
    wait_drained();

    $display("Run covered %0d input beats, %0d of them flushes, under %0d silence levels.",
             beats_sent, flushes_sent, levels_used);
    $display("%0d finished notes were compared, including a long output stall.",
             notes_checked);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== pitch_track_note_segmenter_core.f =====
hw/rtl/ptns_pkg.sv
hw/rtl/pitch_track_note_segmenter_core.sv
tb/sv/ptns_tb_pkg.sv
tb/sv/ptns_note_checker.sv
tb/sv/tb_top.sv
